// ===== rtl/core/sip_pkg.sv =====
// Shared constants and types for the segment intersection point pipeline.
`default_nettype none

package sip_pkg;

  localparam int DEF_COORD_BITS = 10;

  typedef struct packed {
    logic hit;
    logic parallel;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
  } sip_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/sip_div_stage.sv =====
// One restoring-division step for both quotients, with its own pipeline register.
`default_nettype none

module sip_div_stage
  import sip_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int NUM_BITS   = 3 * DEF_COORD_BITS + 5,
  parameter int SHIFT      = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  up_valid,
  output logic                       up_ready,
  input  wire sip_flags_t            up_flags,
  input  wire logic [NUM_BITS-1:0]   up_rx,
  input  wire logic [NUM_BITS-1:0]   up_ry,
  input  wire logic [NUM_BITS-1:0]   up_den,
  input  wire logic [COORD_BITS-1:0] up_qx,
  input  wire logic [COORD_BITS-1:0] up_qy,
  output logic                       dn_valid,
  input  wire logic                  dn_ready,
  output sip_flags_t                 dn_flags,
  output logic [NUM_BITS-1:0]        dn_rx,
  output logic [NUM_BITS-1:0]        dn_ry,
  output logic [NUM_BITS-1:0]        dn_den,
  output logic [COORD_BITS-1:0]      dn_qx,
  output logic [COORD_BITS-1:0]      dn_qy
);

  logic [NUM_BITS-1:0]   den_sh;
  logic                  take_x;
  logic                  take_y;
  logic [COORD_BITS-1:0] qbit;

  assign up_ready = !dn_valid || dn_ready;
  assign den_sh   = up_den << SHIFT;
  assign take_x   = up_rx >= den_sh;
  assign take_y   = up_ry >= den_sh;
  assign qbit     = COORD_BITS'(1) << SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_flags <= up_flags;
      dn_den   <= up_den;
      dn_rx    <= take_x ? up_rx - den_sh : up_rx;
      dn_ry    <= take_y ? up_ry - den_sh : up_ry;
      dn_qx    <= take_x ? (up_qx | qbit) : up_qx;
      dn_qy    <= take_y ? (up_qy | qbit) : up_qy;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/segment_intersection_point.sv =====
// Top level: pipelined segment intersection test and Cramer-rule point.
//
// channel  direction  fields
// s_axis   in         tdata: a_start_x, a_start_y, a_end_x, a_end_y,
//                            b_start_x, b_start_y, b_end_x, b_end_y
// m_axis   out        tdata: hit, parallel, cross_x, cross_y
//
// One request per cycle while m_axis is not stalled; five arithmetic stages,
// then one quotient bit per stage.
// Synchronous reset clears all valid bits.
// Each stage holds while its successor is full and stalled; bubbles are absorbed.
`default_nettype none

module segment_intersection_point
  import sip_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  wire logic [((8*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // hit, parallel, cross_x, cross_y
  output logic [((2*COORD_BITS+2+7)/8)*8-1:0]         m_tdata
);

  localparam int N   = COORD_BITS;
  localparam int PW  = N + 1;
  localparam int MW  = 2 * N + 2;
  localparam int CW  = 2 * N + 3;
  localparam int TW  = 3 * N + 4;
  localparam int NW  = 3 * N + 5;
  localparam int OW  = ((2*N+2+7)/8)*8;

  // ---------------- stage 1: differences and products
  logic [N-1:0] px [8];
  for (genvar g = 0; g < 8; g++) begin : g_unpack
    assign px[g] = s_tdata[g*N +: N];
  end

  function automatic logic signed [PW-1:0] dif(input logic [N-1:0] a, input logic [N-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic signed [MW-1:0] mul(input logic signed [PW-1:0] a,
                                               input logic signed [PW-1:0] b);
    logic signed [MW-1:0] r;
    r = a * b;
    return r;
  endfunction

  function automatic logic in_box(input logic [N-1:0] ax, input logic [N-1:0] ay,
                                  input logic [N-1:0] bx, input logic [N-1:0] by,
                                  input logic [N-1:0] qx, input logic [N-1:0] qy);
    logic [N-1:0] lox, hix, loy, hiy;
    lox = (ax < bx) ? ax : bx;
    hix = (ax < bx) ? bx : ax;
    loy = (ay < by) ? ay : by;
    hiy = (ay < by) ? by : ay;
    return qx >= lox && qx <= hix && qy >= loy && qy <= hiy;
  endfunction

  logic signed [PW-1:0] dx1_0, dy1_0, dx2_0, dy2_0;
  assign dx1_0 = dif(px[2], px[0]);
  assign dy1_0 = dif(px[3], px[1]);
  assign dx2_0 = dif(px[6], px[4]);
  assign dy2_0 = dif(px[7], px[5]);

  logic                 v1, r1;
  logic [N-1:0]         p1 [8];
  logic signed [PW-1:0] dx1_1, dy1_1, dx2_1, dy2_1;
  logic signed [MW-1:0] m1 [14];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      p1    <= px;
      dx1_1 <= dx1_0;
      dy1_1 <= dy1_0;
      dx2_1 <= dx2_0;
      dy2_1 <= dy2_0;
      m1[0]  <= mul(dif(px[0], px[4]), dy2_0);
      m1[1]  <= mul(dx2_0, dif(px[1], px[5]));
      m1[2]  <= mul(dif(px[2], px[4]), dy2_0);
      m1[3]  <= mul(dx2_0, dif(px[3], px[5]));
      m1[4]  <= mul(dif(px[4], px[0]), dy1_0);
      m1[5]  <= mul(dx1_0, dif(px[5], px[1]));
      m1[6]  <= mul(dif(px[6], px[0]), dy1_0);
      m1[7]  <= mul(dx1_0, dif(px[7], px[1]));
      m1[8]  <= mul(dy1_0, $signed({1'b0, px[0]}));
      m1[9]  <= mul(dx1_0, $signed({1'b0, px[1]}));
      m1[10] <= mul(dy2_0, $signed({1'b0, px[4]}));
      m1[11] <= mul(dx2_0, $signed({1'b0, px[5]}));
      m1[12] <= mul(dx1_0, dy2_0);
      m1[13] <= mul(dx2_0, dy1_0);
    end
  end

  // ---------------- stage 2: cross products, line constants, determinant
  logic                 v2, r2;
  logic [N-1:0]         p2 [8];
  logic signed [PW-1:0] dx1_2, dy1_2, dx2_2, dy2_2;
  logic signed [CW-1:0] d2 [4];
  logic signed [CW-1:0] c1_2, c2_2, det_2;

  assign r1 = !v1 || r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      p2    <= p1;
      dx1_2 <= dx1_1;
      dy1_2 <= dy1_1;
      dx2_2 <= dx2_1;
      dy2_2 <= dy2_1;
      for (int k = 0; k < 4; k++) begin
        d2[k] <= CW'(m1[2*k]) - CW'(m1[2*k+1]);
      end
      c1_2  <= CW'(m1[8]) - CW'(m1[9]);
      c2_2  <= CW'(m1[10]) - CW'(m1[11]);
      det_2 <= CW'(m1[12]) - CW'(m1[13]);
    end
  end

  // ---------------- stage 3: hit decision, numerator products
  logic opp12, opp34, meet;
  assign opp12 = (d2[0] > 0 && d2[1] < 0) || (d2[0] < 0 && d2[1] > 0);
  assign opp34 = (d2[2] > 0 && d2[3] < 0) || (d2[2] < 0 && d2[3] > 0);
  assign meet  = (opp12 && opp34)
              || (d2[0] == 0 && in_box(p2[4], p2[5], p2[6], p2[7], p2[0], p2[1]))
              || (d2[1] == 0 && in_box(p2[4], p2[5], p2[6], p2[7], p2[2], p2[3]))
              || (d2[2] == 0 && in_box(p2[0], p2[1], p2[2], p2[3], p2[4], p2[5]))
              || (d2[3] == 0 && in_box(p2[0], p2[1], p2[2], p2[3], p2[6], p2[7]));

  logic                 v3, r3, hit3;
  logic signed [TW-1:0] m3 [4];
  logic signed [CW-1:0] det_3;

  assign r2 = !v2 || r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      hit3  <= meet;
      det_3 <= det_2;
      m3[0] <= TW'(c2_2) * TW'(dx1_2);
      m3[1] <= TW'(c1_2) * TW'(dx2_2);
      m3[2] <= TW'(c2_2) * TW'(dy1_2);
      m3[3] <= TW'(c1_2) * TW'(dy2_2);
    end
  end

  // ---------------- stage 4: numerators, magnitudes and signs
  logic signed [NW-1:0] nx3, ny3;
  assign nx3 = NW'(m3[0]) - NW'(m3[1]);
  assign ny3 = NW'(m3[2]) - NW'(m3[3]);

  logic          v4, r4;
  sip_flags_t    f4;
  logic [NW-1:0] ax4, ay4, ad4;

  assign r3 = !v3 || r4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      f4.hit      <= hit3;
      f4.parallel <= hit3 && (det_3 == 0);
      f4.neg_x    <= nx3[NW-1] ^ det_3[CW-1];
      f4.neg_y    <= ny3[NW-1] ^ det_3[CW-1];
      f4.sat_x    <= 1'b0;
      f4.sat_y    <= 1'b0;
      ax4 <= nx3[NW-1] ? NW'(-nx3) : NW'(nx3);
      ay4 <= ny3[NW-1] ? NW'(-ny3) : NW'(ny3);
      ad4 <= det_3[CW-1] ? NW'(-NW'(det_3)) : NW'(det_3);
    end
  end

  // ---------------- stage 5: saturation check (quotient beyond N bits)
  logic [NW-1:0] dlim4;
  assign dlim4 = ad4 << N;

  sip_flags_t    f4s;
  always_comb begin
    f4s       = f4;
    f4s.sat_x = ax4 >= dlim4;
    f4s.sat_y = ay4 >= dlim4;
  end

  logic          v5, r5;
  sip_flags_t    f5;
  logic [NW-1:0] ax5, ay5, ad5;

  assign r4 = !v4 || r5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (r5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r5) begin
      f5  <= f4s;
      ax5 <= ax4;
      ay5 <= ay4;
      ad5 <= ad4;
    end
  end

  // ---------------- quotient stages
  logic          dv  [N+1];
  logic          dr  [N+1];
  sip_flags_t    df  [N+1];
  logic [NW-1:0] drx [N+1];
  logic [NW-1:0] dry [N+1];
  logic [NW-1:0] dd  [N+1];
  logic [N-1:0]  dqx [N+1];
  logic [N-1:0]  dqy [N+1];

  assign dv[0]  = v5;
  assign df[0]  = f5;
  assign drx[0] = ax5;
  assign dry[0] = ay5;
  assign dd[0]  = ad5;
  assign dqx[0] = '0;
  assign dqy[0] = '0;
  assign r5     = !v5 || dr[0];

  for (genvar k = 0; k < N; k++) begin : g_div
    sip_div_stage #(
      .COORD_BITS (N),
      .NUM_BITS   (NW),
      .SHIFT      (N - 1 - k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (dv[k]),
      .up_ready (dr[k]),
      .up_flags (df[k]),
      .up_rx    (drx[k]),
      .up_ry    (dry[k]),
      .up_den   (dd[k]),
      .up_qx    (dqx[k]),
      .up_qy    (dqy[k]),
      .dn_valid (dv[k+1]),
      .dn_ready (dr[k+1]),
      .dn_flags (df[k+1]),
      .dn_rx    (drx[k+1]),
      .dn_ry    (dry[k+1]),
      .dn_den   (dd[k+1]),
      .dn_qx    (dqx[k+1]),
      .dn_qy    (dqy[k+1])
    );
  end

  // ---------------- output
  sip_flags_t   fo;
  logic         point_ok;
  logic [N-1:0] cross_x, cross_y;

  assign fo       = df[N];
  assign dr[N]    = m_tready;
  assign m_tvalid = dv[N];
  assign s_tready = r1;
  assign point_ok = fo.hit && !fo.parallel;

  always_comb begin
    cross_x = '0;
    cross_y = '0;
    if (point_ok && !fo.neg_x) begin
      cross_x = fo.sat_x ? '1 : dqx[N];
    end
    if (point_ok && !fo.neg_y) begin
      cross_y = fo.sat_y ? '1 : dqy[N];
    end
  end

  assign m_tdata = OW'({cross_y, cross_x, fo.parallel, fo.hit});

  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  assert property (@(posedge clk) disable iff (rst) m_tvalid && fo.parallel |-> fo.hit)
    else $error("parallel without hit");
  assert property (@(posedge clk) disable iff (rst)
                   m_tvalid && !point_ok |-> cross_x == '0 && cross_y == '0)
    else $error("nonzero point without a solved hit");
  assert property (@(posedge clk) disable iff (rst)
                   v5 && !r5 |=> v5 && $stable(ax5) && $stable(ad5))
    else $error("stalled stage lost its contents");

endmodule

`default_nettype wire
